FILE: hw/rtl/sacts_pkg.sv
`default_nettype none

package sacts_pkg;

    localparam int MAX_WAYS = 8;
    localparam int WAY_W    = 3;
    localparam int MAX_SETS = 256;
    localparam int SET_W    = 8;
    localparam int OFFSET_W = 4;
    localparam int ADDR_W   = 48;
    localparam int TAG_W    = ADDR_W - OFFSET_W;
    localparam int AGE_W    = 3;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [AGE_W-1:0] AGE_MAX        = 3'd7;
    localparam logic [CFG_W-1:0] SETS_LOG2_MAX  = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYS_LOG2 = 2'd0,
        CFG_SETS_LOG2 = 2'd1,
        CFG_POLICY    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        POLICY_LRU  = 1'b0,
        POLICY_FIFO = 1'b1
    } policy_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    // one memory row holds a whole set
    typedef struct packed {
        logic [WAY_W-1:0]                  fifo_ptr;
        logic [MAX_WAYS-1:0]               valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0]    age;
        logic [MAX_WAYS-1:0][TAG_W-1:0]    tag;
    } row_t;

endpackage

`default_nettype wire

FILE: hw/rtl/set_assoc_cache_tag_store_unit.sv
// Tag store of a set-associative cache with 16-byte lines, 1 to 8 ways and up to 256 sets,
// LRU or FIFO replacement. Each address takes two steps: its set's row is read from the tag
// memory, then the ways are compared, the victim picked and the row written back. A new
// address is taken only when the previous one has written back, so accesses to the same
// set never overlap. A result that is not taken holds the following address in its
// compare cycle. Rows come out of reset as empty through per-set flags, so there is no
// clearing pass. Configuration is not a flush: lines keep their state under new geometry.
`default_nettype none

module set_assoc_cache_tag_store_unit
    import sacts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_W-1:0]    s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [WAY_W-1:0]     m_way_used,
    output logic [CNT_W-1:0]     m_access_total,
    output logic [CNT_W-1:0]     m_miss_total
);

    logic [1:0]        ways_log2_reg;
    logic [CFG_W-1:0]  sets_log2_reg;
    policy_t           policy_reg;

    state_t            state_reg, state_next;
    logic              accept;
    logic              lookup_done;

    row_t              row_mem [MAX_SETS];
    row_t              rd_row_reg;
    logic              rd_init_reg;
    logic [MAX_SETS-1:0] row_init_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SET_W-1:0]  set_reg;

    logic [CNT_W-1:0]  access_reg, miss_reg;
    logic [CNT_W-1:0]  access_next, miss_next;

    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [WAY_W-1:0]  m_way_reg;
    logic [CNT_W-1:0]  m_access_reg, m_miss_reg;

    logic [CFG_W-1:0]  sl_eff;
    logic [SET_W:0]    mask_full;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  s_set;
    logic [WAY_W-1:0]  way_mask;
    logic [MAX_WAYS-1:0] way_active;

    row_t              cur_row;
    row_t              row_next;
    logic [TAG_W-1:0]  lk_tag;
    logic [MAX_WAYS-1:0] hit_vec, inv_vec;
    logic              lk_hit, lk_found;
    logic [WAY_W-1:0]  hit_way, inv_way, lru_way, fifo_way, sel_way;
    logic [AGE_W-1:0]  lru_age;
    logic [AGE_W:0]    old_age;
    logic              fifo_evict;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_log2_reg <= '0;
            sets_log2_reg <= SETS_LOG2_MAX;
            policy_reg    <= POLICY_LRU;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_WAYS_LOG2: ways_log2_reg <= cfg_wdata[1:0];
                CFG_SETS_LOG2: sets_log2_reg <= cfg_wdata;
                CFG_POLICY:    policy_reg    <= policy_t'(cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    // geometry
    always_comb begin
        sl_eff    = (sets_log2_reg > SETS_LOG2_MAX) ? SETS_LOG2_MAX : sets_log2_reg;
        mask_full = (SET_W+1)'(1) << sl_eff;
        set_mask  = SET_W'(mask_full - 1'b1);
        s_set     = s_address[OFFSET_W +: SET_W] & set_mask;
        way_mask  = WAY_W'((4'd1 << ways_log2_reg) - 4'd1);
        for (int v = 0; v < MAX_WAYS; v++) begin
            way_active[v] = ((WAY_W'(v) & ~way_mask) == '0);
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LOOKUP;
            ST_LOOKUP: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        lookup_done = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_LOOKUP: lookup_done = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // tag memory: read on accept, write back at the end of the lookup
    always_ff @(posedge aclk) begin
        if (lookup_done) begin
            row_mem[set_reg] <= row_next;
        end
        if (accept) begin
            rd_row_reg <= row_mem[s_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_init_reg <= row_init_reg[s_set];
            addr_reg    <= s_address;
            set_reg     <= s_set;
        end
    end

    // a set not yet written since reset reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg <= '0;
        end else if (lookup_done) begin
            row_init_reg[set_reg] <= 1'b1;
        end
    end

    // compare and replacement
    always_comb begin
        cur_row = rd_init_reg ? rd_row_reg : row_t'('0);
        lk_tag  = TAG_W'(addr_reg[ADDR_W-1:OFFSET_W] >> sl_eff);

        for (int v = 0; v < MAX_WAYS; v++) begin
            hit_vec[v] = way_active[v] && cur_row.valid[v] && (cur_row.tag[v] == lk_tag);
            inv_vec[v] = way_active[v] && !cur_row.valid[v];
        end
        lk_hit   = |hit_vec;
        lk_found = |inv_vec;

        hit_way = '0;
        inv_way = '0;
        for (int v = MAX_WAYS - 1; v >= 0; v--) begin
            if (hit_vec[v]) hit_way = WAY_W'(v);
            if (inv_vec[v]) inv_way = WAY_W'(v);
        end

        // oldest way, ties to the lowest
        lru_way = '0;
        lru_age = cur_row.age[0];
        for (int v = 1; v < MAX_WAYS; v++) begin
            if (way_active[v] && (cur_row.age[v] > lru_age)) begin
                lru_way = WAY_W'(v);
                lru_age = cur_row.age[v];
            end
        end
        fifo_way = cur_row.fifo_ptr & way_mask;

        fifo_evict = 1'b0;
        if (lk_hit) begin
            sel_way = hit_way;
            old_age = {1'b0, cur_row.age[hit_way]};
        end else if (lk_found) begin
            // an empty way counts as older than any valid one
            sel_way = inv_way;
            old_age = {1'b0, AGE_MAX} + 1'b1;
        end else if (policy_reg == POLICY_FIFO) begin
            sel_way    = fifo_way;
            old_age    = {1'b0, cur_row.age[fifo_way]};
            fifo_evict = 1'b1;
        end else begin
            sel_way = lru_way;
            old_age = {1'b0, lru_age};
        end

        row_next = cur_row;
        if (!lk_hit) begin
            row_next.tag[sel_way]   = lk_tag;
            row_next.valid[sel_way] = 1'b1;
        end
        if (fifo_evict) begin
            row_next.fifo_ptr = (sel_way + 1'b1) & way_mask;
        end
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (way_active[v] && (WAY_W'(v) != sel_way) && cur_row.valid[v]
                && ({1'b0, cur_row.age[v]} < old_age) && (cur_row.age[v] != AGE_MAX)) begin
                row_next.age[v] = cur_row.age[v] + 1'b1;
            end
        end
        row_next.age[sel_way] = '0;
    end

    // saturating counts
    always_comb begin
        access_next = (access_reg != '1) ? access_reg + 1'b1 : access_reg;
        miss_next   = (!lk_hit && (miss_reg != '1)) ? miss_reg + 1'b1 : miss_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_reg  <= '0;
            miss_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (lookup_done) begin
            access_reg  <= access_next;
            miss_reg    <= miss_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup_done) begin
            m_hit_reg    <= lk_hit;
            m_way_reg    <= sel_way;
            m_access_reg <= access_next;
            m_miss_reg   <= miss_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_way_used     = m_way_reg;
    assign m_access_total = m_access_reg;
    assign m_miss_total   = m_miss_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sacts_checker.sv
`default_nettype none

module sacts_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_hit,
    input wire [2:0]  m_way_used,
    input wire [31:0] m_access_total,
    input wire [31:0] m_miss_total
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_way_used)
            && $stable(m_access_total) && $stable(m_miss_total))
        else $error("result word changed while stalled");

    a_miss_le_access: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_miss_total <= m_access_total)
        else $error("miss count above access count");

    // one address in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("address taken during lookup");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (!m_valid || m_ready) |=> m_valid)
        else $error("no result after lookup with free output");

endmodule

bind set_assoc_cache_tag_store_unit sacts_checker u_sacts_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_way_used     (m_way_used),
    .m_access_total (m_access_total),
    .m_miss_total   (m_miss_total)
);

`default_nettype wire

FILE: tb/tb_set_assoc_cache_tag_store_unit.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_store_unit;
    import sacts_pkg::*;

    typedef struct {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] accesses;
        logic [CNT_W-1:0] misses;
    } access_result_t;

    typedef enum logic {
        ROW_ACCESS = 1'b0,
        ROW_WRITE  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        cfg_index_t       reg_idx;
        logic [CFG_W-1:0] value;
        logic [ADDR_W-1:0] addr;
        bit               typed;
        logic             hit;
        logic [WAY_W-1:0] way;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_address;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_hit;
    logic [WAY_W-1:0]     m_way_used;
    logic [CNT_W-1:0]     m_access_total;
    logic [CNT_W-1:0]     m_miss_total;

    set_assoc_cache_tag_store_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_way_used     (m_way_used),
        .m_access_total (m_access_total),
        .m_miss_total   (m_miss_total)
    );

    // shadow copy of the tag store
    logic                 tag_valid  [MAX_WAYS*MAX_SETS];
    logic [TAG_W-1:0]     tag_word   [MAX_WAYS*MAX_SETS];
    logic [AGE_W-1:0]     line_rank  [MAX_WAYS*MAX_SETS];
    logic [WAY_W-1:0]     victim_ptr [MAX_SETS];
    logic [CNT_W-1:0]     seen_count;
    logic [CNT_W-1:0]     miss_count;
    logic [1:0]           assoc_log2;
    logic [CFG_W-1:0]     set_log2_cfg;
    policy_t              repl_policy;

    access_result_t       pending_results [$];
    int                   mismatch_count;
    int                   burst_left;

    int phase_ways   [12] = '{3, 0, 1, 2, 3, 2, 1, 3, 0, 3, 2, 1};
    int phase_sets   [12] = '{8, 0, 15, 1, 3, 8, 9, 2, 4, 0, 6, 8};
    int phase_policy [12] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 0};

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("set_assoc_cache_tag_store_unit: mismatch");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr);
        int               sl;
        int               ways;
        int               set_idx;
        int               base;
        int               w;
        int               v;
        int               old_age;
        bit               hit;
        bit               found;
        logic [TAG_W-1:0] tag;
        access_result_t   r;
        sl      = (set_log2_cfg > SETS_LOG2_MAX) ? int'(SETS_LOG2_MAX) : int'(set_log2_cfg);
        ways    = 1 << assoc_log2;
        set_idx = int'((64'(addr) >> OFFSET_W) & ((64'd1 << sl) - 1));
        tag     = TAG_W'(addr >> (OFFSET_W + sl));
        base    = set_idx * MAX_WAYS;
        if (seen_count != '1)
            seen_count++;
        hit = 1'b0;
        w   = 0;
        for (v = 0; v < ways; v++) begin
            if (!hit && tag_valid[base+v] && tag_word[base+v] == tag) begin
                hit = 1'b1;
                w   = v;
            end
        end
        if (hit) begin
            old_age = line_rank[base+w];
        end else begin
            if (miss_count != '1)
                miss_count++;
            found = 1'b0;
            for (v = 0; v < ways; v++) begin
                if (!found && !tag_valid[base+v]) begin
                    found = 1'b1;
                    w     = v;
                end
            end
            if (found) begin
                // an empty way is older than anything in the set
                old_age = int'(AGE_MAX) + 1;
            end else if (repl_policy == POLICY_FIFO) begin
                w = victim_ptr[set_idx] & (ways - 1);
                victim_ptr[set_idx] = WAY_W'((w + 1) & (ways - 1));
                old_age = line_rank[base+w];
            end else begin
                w = 0;
                for (v = 1; v < ways; v++)
                    if (line_rank[base+v] > line_rank[base+w])
                        w = v;
                old_age = line_rank[base+w];
            end
            tag_word[base+w]  = tag;
            tag_valid[base+w] = 1'b1;
        end
        for (v = 0; v < ways; v++) begin
            if (v != w && tag_valid[base+v] && line_rank[base+v] < old_age
                    && line_rank[base+v] < AGE_MAX)
                line_rank[base+v]++;
        end
        line_rank[base+w] = '0;
        r.hit      = hit;
        r.way      = WAY_W'(w);
        r.accesses = seen_count;
        r.misses   = miss_count;
        return r;
    endfunction

    task automatic send_address(input logic [ADDR_W-1:0] a);
        s_valid   <= 1'b1;
        s_address <= a;
        do @(posedge aclk); while (!s_ready);
    endtask

    // bursts with random gaps in between
    task automatic pace_input();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_WAYS_LOG2: assoc_log2   = val[1:0];
            CFG_SETS_LOG2: set_log2_cfg = val;
            CFG_POLICY:    repl_policy  = policy_t'(val[0]);
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic plan_row_t access_row(input logic [ADDR_W-1:0] a, input bit typed,
                                             input logic hit, input logic [WAY_W-1:0] way);
        plan_row_t r;
        r.kind    = ROW_ACCESS;
        r.reg_idx = CFG_WAYS_LOG2;
        r.value   = '0;
        r.addr    = a;
        r.typed   = typed;
        r.hit     = hit;
        r.way     = way;
        return r;
    endfunction

    function automatic plan_row_t config_row(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        plan_row_t r;
        r       = access_row('0, 1'b0, 1'b0, '0);
        r.kind  = ROW_WRITE;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    // result side: stall patterns picked at random, plus long hold-offs
    initial begin
        int cyc;
        int mode;
        int hold_left;
        int words_taken;
        int next_hold_at;
        m_ready      <= 1'b0;
        cyc          = 0;
        mode         = 0;
        hold_left    = 0;
        words_taken  = 0;
        next_hold_at = 300;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                words_taken++;
            cyc++;
            if (cyc % 48 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left == 0 && words_taken >= next_hold_at) begin
                hold_left    = 250;
                next_hold_at = next_hold_at + 900;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (cyc % 3 == 0);
                    default: m_ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit)
                    note_mismatch($sformatf("hit %b, expected %b", m_hit, want.hit));
                if (m_way_used !== want.way)
                    note_mismatch($sformatf("way_used %0d, expected %0d",
                                            m_way_used, want.way));
                if (m_access_total !== want.accesses)
                    note_mismatch($sformatf("access_total %0d, expected %0d",
                                            m_access_total, want.accesses));
                if (m_miss_total !== want.misses)
                    note_mismatch($sformatf("miss_total %0d, expected %0d",
                                            m_miss_total, want.misses));
            end
        end
    end

    initial begin
        plan_row_t         plan [$];
        access_result_t    got;
        logic [TAG_W+OFFSET_W+SET_W-1:0] tag_pool [18];
        logic [63:0]       wide;
        logic [ADDR_W-1:0] addr;
        int                hot_set [2];
        int                eff_sets;
        int                pool_size;
        int                ph;
        int                n;
        int                k;

        cfg_wr_en  <= 1'b0;
        cfg_index  <= CFG_WAYS_LOG2;
        cfg_wdata  <= '0;
        s_valid    <= 1'b0;
        s_address  <= '0;
        aresetn    <= 1'b0;
        mismatch_count = 0;
        burst_left     = 0;

        for (k = 0; k < MAX_WAYS*MAX_SETS; k++) begin
            tag_valid[k] = 1'b0;
            tag_word[k]  = '0;
            line_rank[k] = '0;
        end
        for (k = 0; k < MAX_SETS; k++)
            victim_ptr[k] = '0;
        seen_count   = '0;
        miss_count   = '0;
        assoc_log2   = 2'd0;
        set_log2_cfg = 4'd8;
        repl_policy  = POLICY_LRU;

        // one way, 256 sets, lru after reset
        plan.push_back(access_row(48'h0, 1'b1, 1'b0, 3'd0));
        plan.push_back(access_row(48'h0, 1'b1, 1'b1, 3'd0));
        plan.push_back(access_row(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0));
        plan.push_back(access_row(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 3'd0));
        plan.push_back(access_row(48'h1000, 1'b1, 1'b0, 3'd0));
        // eight ways: the rest of set 0 fills in order
        plan.push_back(config_row(CFG_WAYS_LOG2, 4'd3));
        for (k = 2; k <= 8; k++)
            plan.push_back(access_row(ADDR_W'(k) << 12, 1'b1, 1'b0, WAY_W'(k - 1)));
        plan.push_back(access_row(48'h1000, 1'b1, 1'b1, 3'd0));
        // way 1 is now the oldest
        plan.push_back(access_row(48'h9000, 1'b1, 1'b0, 3'd1));
        plan.push_back(config_row(CFG_POLICY, 4'(POLICY_FIFO)));
        plan.push_back(access_row(48'hA000, 1'b1, 1'b0, 3'd0));
        plan.push_back(access_row(48'hB000, 1'b1, 1'b0, 3'd1));
        // two ways: round-robin pointer of 2 wraps to way 0
        plan.push_back(config_row(CFG_WAYS_LOG2, 4'd1));
        plan.push_back(access_row(48'hC000, 1'b1, 1'b0, 3'd0));
        // out-of-range set count behaves as 256 sets
        plan.push_back(config_row(CFG_SETS_LOG2, 4'd15));
        plan.push_back(access_row(48'hB000, 1'b1, 1'b1, 3'd1));
        // single set, no flush: old lines are read under the new tag split
        plan.push_back(config_row(CFG_SETS_LOG2, 4'd0));
        plan.push_back(access_row(48'hC5, 1'b1, 1'b1, 3'd0));
        plan.push_back(access_row(48'h0, 1'b1, 1'b0, 3'd1));
        plan.push_back(access_row(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0));
        plan.push_back(access_row(48'hFFFF_FFFF_FFF0, 1'b0, 1'b0, 3'd0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_for_drain();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_address(plan[i].addr);
                got = predict_access(plan[i].addr);
                if (plan[i].typed) begin
                    got.hit = plan[i].hit;
                    got.way = plan[i].way;
                end
                pending_results.push_back(got);
            end
        end

        for (ph = 0; ph < 12; ph++) begin
            wait_for_drain();
            // junk in the unused upper bits of the narrow registers
            write_reg(CFG_WAYS_LOG2, {2'($urandom), 2'(phase_ways[ph])});
            write_reg(CFG_SETS_LOG2, 4'(phase_sets[ph]));
            write_reg(CFG_POLICY, {3'($urandom), 1'(phase_policy[ph])});
            eff_sets = (set_log2_cfg > SETS_LOG2_MAX) ? int'(SETS_LOG2_MAX)
                                                      : int'(set_log2_cfg);
            pool_size = 2 * (1 << assoc_log2) + 2;
            hot_set[0] = $urandom_range(0, (1 << eff_sets) - 1);
            hot_set[1] = $urandom_range(0, (1 << eff_sets) - 1);
            for (k = 0; k < pool_size; k++)
                tag_pool[k] = (TAG_W+OFFSET_W+SET_W)'({$urandom, $urandom});
            for (n = 0; n < 150; n++) begin
                if ($urandom_range(0, 9) < 8) begin
                    // a few tags fighting over two sets: hits, fills and evictions
                    wide = (64'(tag_pool[$urandom_range(0, pool_size - 1)])
                                << (OFFSET_W + eff_sets))
                         | (64'(hot_set[$urandom_range(0, 1)]) << OFFSET_W)
                         | 64'($urandom_range(0, 15));
                end else begin
                    wide = {$urandom, $urandom};
                end
                addr = ADDR_W'(wide);
                send_address(addr);
                got = predict_access(addr);
                pending_results.push_back(got);
                if (ph == 5 && n == 75)
                    wait_for_drain();
                else if (n != 149)
                    pace_input();
            end
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("set_assoc_cache_tag_store_unit: match");
        end else begin
            $display("set_assoc_cache_tag_store_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: set_assoc_cache_tag_store_unit.f
hw/rtl/sacts_pkg.sv
hw/rtl/set_assoc_cache_tag_store_unit.sv
hw/rtl/sacts_checker.sv
tb/tb_set_assoc_cache_tag_store_unit.sv
